// ----- hw/rtl/b32e_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Base32 encoder package
// Shared types, constants and the symbol alphabet lookup.
// ----------------------------------------------------------------------------
package b32e_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam int SYM_W   = 5;
    localparam int CHAR_W  = 7;
    localparam int BYTE_W  = 8;

    // byte position within a five-byte group
    localparam logic [2:0] POS_0 = 3'd0;
    localparam logic [2:0] POS_1 = 3'd1;
    localparam logic [2:0] POS_2 = 3'd2;
    localparam logic [2:0] POS_3 = 3'd3;
    localparam logic [2:0] POS_4 = 3'd4;

    localparam logic [CHAR_W-1:0] PAD_CHAR = 7'd61;   // '='

    // one command per byte: up to three symbols, then pads
    typedef struct packed {
        logic [2:0][SYM_W-1:0] sym;
        logic [1:0]            sym_cnt;   // 1..3
        logic [2:0]            last_idx;  // total characters - 1
        logic                  fin;
    } cmd_t;

    localparam int CMD_W = $bits(cmd_t);

    // A-Z then 2-7
    function automatic logic [CHAR_W-1:0] sym_to_char(input logic [SYM_W-1:0] v);
        logic [CHAR_W-1:0] c;
        if (v < 5'd26)
            c = 7'd65 + {2'b00, v};
        else
            c = 7'd24 + {2'b00, v};   // '2' - 26
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/b32e_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Base32 encoder front end
// Tracks group position and leftover bits; turns each byte into a command.
// ----------------------------------------------------------------------------
module b32e_front
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic [b32e_pkg::BYTE_W-1:0]  data_byte,
    input  wire logic                         final_byte,
    input  wire logic                         take,
    output b32e_pkg::cmd_t                    cmd
);

    logic [2:0] pos_reg, pos_next;
    logic [3:0] lo_reg, lo_next;

    logic [2:0]                       p;
    logic [3:0]                       lo_new;
    logic [b32e_pkg::SYM_W-1:0]       tail;
    logic                             has_tail;
    logic [2:0]                       pads;
    logic [1:0]                       cnt;
    logic [3:0]                       total;

    always_comb
    begin
        p = (pos_reg > b32e_pkg::POS_4) ? b32e_pkg::POS_0 : pos_reg;
        cmd.sym  = '0;
        has_tail = 1'b1;
        case (p)
            b32e_pkg::POS_0:
            begin
                cmd.sym[0] = data_byte[7:3];
                lo_new     = {1'b0, data_byte[2:0]};
                tail       = {data_byte[2:0], 2'b00};
                pads       = 3'd6;
                cnt        = 2'd1;
            end
            b32e_pkg::POS_1:
            begin
                cmd.sym[0] = {lo_reg[2:0], data_byte[7:6]};
                cmd.sym[1] = data_byte[5:1];
                lo_new     = {3'b000, data_byte[0]};
                tail       = {data_byte[0], 4'b0000};
                pads       = 3'd4;
                cnt        = 2'd2;
            end
            b32e_pkg::POS_2:
            begin
                cmd.sym[0] = {lo_reg[0], data_byte[7:4]};
                lo_new     = data_byte[3:0];
                tail       = {data_byte[3:0], 1'b0};
                pads       = 3'd3;
                cnt        = 2'd1;
            end
            b32e_pkg::POS_3:
            begin
                cmd.sym[0] = {lo_reg[3:0], data_byte[7]};
                cmd.sym[1] = data_byte[6:2];
                lo_new     = {2'b00, data_byte[1:0]};
                tail       = {data_byte[1:0], 3'b000};
                pads       = 3'd1;
                cnt        = 2'd2;
            end
            default:
            begin
                cmd.sym[0] = {lo_reg[1:0], data_byte[7:5]};
                cmd.sym[1] = data_byte[4:0];
                lo_new     = 4'd0;
                tail       = '0;
                has_tail   = 1'b0;
                pads       = 3'd0;
                cnt        = 2'd2;
            end
        endcase

        if (final_byte && has_tail)
        begin
            if (cnt == 2'd1)
                cmd.sym[1] = tail;
            else
                cmd.sym[2] = tail;
            cnt = cnt + 2'd1;
        end
        if (!final_byte)
            pads = 3'd0;

        total        = {2'b00, cnt} + {1'b0, pads};
        cmd.sym_cnt  = cnt;
        cmd.last_idx = 3'(total - 4'd1);
        cmd.fin      = final_byte;

        pos_next = pos_reg;
        lo_next  = lo_reg;
        if (in_valid && take)
        begin
            if (final_byte || p == b32e_pkg::POS_4)
            begin
                pos_next = b32e_pkg::POS_0;
                lo_next  = 4'd0;
            end
            else
            begin
                pos_next = p + 3'd1;
                lo_next  = lo_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= b32e_pkg::POS_0;
            lo_reg  <= 4'd0;
        end
        else
        begin
            pos_reg <= pos_next;
            lo_reg  <= lo_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/b32e_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Base32 encoder command queue
// Small FIFO of commands between the front end and the character emitter.
// ----------------------------------------------------------------------------
module b32e_queue
#(
    parameter int DEPTH = b32e_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  b32e_pkg::cmd_t      push_cmd,
    output logic                full,
    input  wire logic           pop,
    output logic                empty,
    output b32e_pkg::cmd_t      head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    b32e_pkg::cmd_t entries [DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    logic do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = entries[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_ADDR) ? '0 : wr_ptr_reg + AW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_ADDR) ? '0 : rd_ptr_reg + AW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/b32e_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Base32 encoder back end
// Walks each command into a registered output, one character per ready cycle.
// ----------------------------------------------------------------------------
module b32e_back
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_valid,
    input  b32e_pkg::cmd_t                     cmd,
    output logic                               cmd_pop,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [b32e_pkg::CHAR_W-1:0]        out_char,
    output logic                               is_last
);

    logic [2:0]                   idx_reg, idx_next;
    logic                         valid_reg, valid_next;
    logic [b32e_pkg::CHAR_W-1:0]  char_reg, char_next;
    logic                         last_reg, last_next;
    logic                         load, at_end;

    assign load      = !valid_reg || out_ready;
    assign at_end    = (idx_reg == cmd.last_idx);
    assign cmd_pop   = load && cmd_valid && at_end;
    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign is_last   = last_reg;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = cmd_valid;
            if (cmd_valid)
            begin
                if (idx_reg < {1'b0, cmd.sym_cnt})
                    char_next = b32e_pkg::sym_to_char(cmd.sym[idx_reg[1:0]]);
                else
                    char_next = b32e_pkg::PAD_CHAR;
                last_next = cmd.fin && at_end;
                idx_next  = at_end ? 3'd0 : idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

endmodule
`default_nettype wire

// ----- hw/rtl/base32_stream_encoder_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Base32 stream encoder
// Bytes in, standard base32 characters out, padded and marked on the last byte.
// ----------------------------------------------------------------------------
// A byte's command is registered in the queue, then each character in the
// output register. Throughput: one character per cycle while m_axis_tready is
//   high; 1 or 2 characters per byte (up to 8 on a final one), about 1.6 average.
// Bytes are accepted every cycle while the command queue has room.
// Reset (rst_n low, async): group position, leftover bits and queue clear.
module base32_stream_encoder_unit
#(
    parameter int QUEUE_DEPTH = b32e_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,   // final_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [6:0] out_char, [7] zero
    output logic             m_axis_tlast    // is_last
);

    b32e_pkg::cmd_t                front_cmd, head_cmd;
    logic                          q_full, q_empty, q_pop;
    logic [b32e_pkg::CHAR_W-1:0]   out_char;

    assign s_axis_tready = !q_full;

    b32e_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .data_byte  (s_axis_tdata),
        .final_byte (s_axis_tlast),
        .take       (!q_full),
        .cmd        (front_cmd)
    );

    b32e_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (s_axis_tvalid),
        .push_cmd (front_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (head_cmd)
    );

    b32e_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!q_empty),
        .cmd       (head_cmd),
        .cmd_pop   (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_char  (out_char),
        .is_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_char};

endmodule
`default_nettype wire
